// ===== rtl/shpe_pkg.sv =====
// Package: shared constants and types for the sync header payload extractor.
`default_nettype none

package shpe_pkg;

  localparam int HdrLen  = 32;
  localparam int CellCnt = HdrLen - 1;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] len_t;

  localparam len_t LenReset = 16'd400;

  localparam byte_t HdrPattern [HdrLen] = '{
    8'd2, 8'd2, 8'd3, 8'd0, 8'd3, 8'd1, 8'd3, 8'd1,
    8'd2, 8'd2, 8'd1, 8'd0, 8'd3, 8'd2, 8'd0, 8'd2,
    8'd3, 8'd3, 8'd0, 8'd2, 8'd2, 8'd0, 8'd3, 8'd0,
    8'd0, 8'd2, 8'd0, 8'd0, 8'd3, 8'd3, 8'd3, 8'd0
  };

  // Per-cell shift control, common to the whole chain.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/shpe_cell.sv =====
// Module: one history cell; holds a byte and a valid flag, compares to its pattern byte.
`default_nettype none

module shpe_cell
  import shpe_pkg::*;
#(
  parameter byte_t PatByte = 8'd0
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  byte_t      byte_i,
  input  wire        vld_i,
  output byte_t      byte_o,
  output logic       vld_o,
  output logic       hit_o
);

  byte_t byte_q;
  logic  vld_q;

  // Clear wins over shift: a found header empties the window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  assign vld_o  = vld_q;
  assign hit_o  = vld_q && (byte_q == PatByte);

endmodule

`default_nettype wire

// ===== rtl/sync_header_payload_extractor_top.sv =====
// Module: top level of the sync header payload extractor.
// Usage:
//   Input stream (s_axis_*): one received byte per transaction in tdata[7:0].
//   While hunting, bytes enter a chain of 31 history cells; each cell compares
//   its byte with its pattern position, and the incoming byte is compared with
//   the last header position, so a complete 32-byte header is recognised on
//   the transaction that finishes it. Hunted bytes produce no output.
//   After a header the next payload_length bytes (zero acts as one) pass to
//   the output stream (m_axis_*): tdata[7:0] payload byte, tuser first byte of
//   the frame, tlast final byte of the frame. The window is then empty again.
//   Throughput: one transaction per cycle, sustained while m_axis takes each result; the chain
//   shifts once per accepted byte and the header compare is a combinational parallel check.
//   Output: a payload byte appears on m_axis in the cycle after acceptance, held
//   in the output register.
//   Stall: while the output register holds an untaken result, s_axis_tready
//   follows m_axis_tready, so nothing is lost; it stays high otherwise.
//   Config: cfg_we_i writes payload_length from cfg_wdata_i; it applies from
//   the next detected header.
//   Reset: asynchronous, active low; window empty, hunting, length 400.
`default_nettype none

module sync_header_payload_extractor_top
  import shpe_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] symbol
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] payload_byte
  output logic        m_axis_tuser,   // [0] first_of_frame
  output logic        m_axis_tlast    // last_of_frame
);

  // Payload length register
  len_t len_q;

  // Copy-mode control
  logic copying_q, copying_d;
  logic start_q, start_d;
  len_t left_q, left_d;

  // Output register
  logic  out_vld_q, out_vld_d;
  byte_t out_byte_q;
  logic  out_first_q;
  logic  out_last_q;

  logic       s_fire;
  logic       shift_en;
  logic       tail_eq;
  logic       match;
  logic       last_byte;
  cell_ctrl_t ctrl;

  // Chain wiring: cell k holds window position k, compared to pattern[k].
  byte_t                chain_byte [CellCnt+1];
  logic  [CellCnt:0]    chain_vld;
  logic  [CellCnt-1:0]  hit;

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign shift_en      = s_fire && !copying_q;

  assign tail_eq = (s_axis_tdata == HdrPattern[HdrLen-1]);
  assign match   = shift_en && (&hit) && tail_eq;

  assign ctrl = '{shift: shift_en, clear: match};

  // Incoming byte enters the top of the chain and is always valid.
  assign chain_byte[CellCnt] = s_axis_tdata;
  assign chain_vld[CellCnt]  = 1'b1;

  for (genvar k = 0; k < CellCnt; k++) begin : g_cell
    shpe_cell #(
      .PatByte (HdrPattern[k])
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .byte_i (chain_byte[k+1]),
      .vld_i  (chain_vld[k+1]),
      .byte_o (chain_byte[k]),
      .vld_o  (chain_vld[k]),
      .hit_o  (hit[k])
    );
  end

  // Position 0 of the old window falls out on every shift; cell 0's outputs feed
  // no further cell, though its byte is still compared inside cell 0.
  logic unused_tail;
  assign unused_tail = ^{chain_byte[0], chain_vld[0]};

  assign last_byte = (left_q <= 16'd1);

  always_comb begin
    copying_d = copying_q;
    start_d   = start_q;
    left_d    = left_q;
    if (match) begin
      copying_d = 1'b1;
      start_d   = 1'b1;
      left_d    = (len_q == 16'd0) ? 16'd1 : len_q;
    end else if (s_fire && copying_q) begin
      start_d = 1'b0;
      if (last_byte) begin
        copying_d = 1'b0;
        left_d    = 16'd0;
      end else begin
        left_d = left_q - 16'd1;
      end
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (s_fire && copying_q) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= LenReset;
      copying_q <= 1'b0;
      start_q   <= 1'b0;
      left_q    <= 16'd0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      copying_q <= copying_d;
      start_q   <= start_d;
      left_q    <= left_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && copying_q) begin
      out_byte_q  <= s_axis_tdata;
      out_first_q <= start_q;
      out_last_q  <= last_byte;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_byte_q ^ {7'd0, 1'b0 & unused_tail};
  assign m_axis_tuser  = out_first_q;
  assign m_axis_tlast  = out_last_q;

  // Assertions
  a_match_starts_copy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    match |=> (copying_q && start_q))
    else $error("header match did not enter copy mode");

  a_left_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    copying_q |-> (left_q != 16'd0))
    else $error("copy mode with no bytes left");

  a_last_ends_copy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && copying_q && last_byte) |=> (!copying_q && m_axis_tvalid && m_axis_tlast))
    else $error("final payload byte did not end the frame");

  a_start_only_copy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> copying_q)
    else $error("frame start mark outside copy mode");

  a_hunt_no_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (shift_en && !m_axis_tready) |=> ($stable(m_axis_tvalid)))
    else $error("hunted byte changed the output");

endmodule

`default_nettype wire
